[hdl/isl_pkg.sv]
package isl_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned SEG_W   = 8;
   localparam int unsigned FRAC_W  = 17;
   localparam int unsigned FBITS   = 16;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ORDER = 2'd3;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FBITS;
   localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_LOAD0,
      S_LOAD1,
      S_DIV,
      S_DONE
   } state_type;

endpackage

[hdl/isl_req_if.sv]
interface isl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           command;
   logic signed [isl_pkg::VALUE_W-1:0]   value;

   modport source (output valid, command, value, input ready);
   modport sink   (input valid, command, value, output ready);
endinterface

[hdl/isl_rsp_if.sv]
interface isl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [isl_pkg::SEG_W-1:0]      segment_index;
   logic [isl_pkg::FRAC_W-1:0]     fraction;
   logic [1:0]                     status;

   modport source (output valid, segment_index, fraction, status, input ready);
   modport sink   (input valid, segment_index, fraction, status, output ready);
endinterface

[hdl/interp_segment_locator_core.sv]
// Segment locator for piecewise linear interpolation. Holds an ascending table of up to
// TABLE_DEPTH signed Q16.16 breakpoints in a one-write, one-read memory; each command item
// (clear, append, query) returns exactly one result item. One item is worked at a time and
// req_chan is ready only while the sequencer is idle. Clear, append, and queries that fall
// outside or at the ends of the table go straight from accept to the result. An interior
// query runs binary-search steps (up to ceil(log2(count-1)) steps, 8 for a full 256-entry
// table), each a read in S_SEARCH and a compare in S_CMP, then fetches the bracketing
// breakpoints and loads the divider (S_LOAD0, S_LOAD1), then runs a one-bit-per-cycle
// restoring divider for the Q1.16 fraction before the result state.
module interp_segment_locator_core #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   isl_req_if.sink      req_chan,
   isl_rsp_if.source    rsp_chan
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned VW    = isl_pkg::VALUE_W;
   localparam int unsigned SW    = isl_pkg::SEG_W;
   localparam int unsigned FW    = isl_pkg::FRAC_W;
   localparam int unsigned FB    = isl_pkg::FBITS;

   isl_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VW-1:0]    first_ff, first_in;
   logic signed [VW-1:0]    last_ff, last_in;
   logic signed [VW-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic signed [VW-1:0]    e0_ff, e0_in;
   logic [VW:0]             rem_ff, rem_in;
   logic [VW-1:0]           den_ff, den_in;
   logic [3:0]              step_ff, step_in;
   logic [SW-1:0]           seg_ff, seg_in;
   logic [FW-1:0]           frac_ff, frac_in;
   logic [1:0]              status_ff, status_in;

   logic signed [VW-1:0]    bp_mem [TABLE_DEPTH];
   logic signed [VW-1:0]    rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;

   logic                    accept;
   logic                    is_full;
   logic                    is_interior;
   logic [IDX_W-1:0]        mid_calc;
   logic [VW-1:0]           num_calc;
   logic [VW-1:0]           den_calc;
   logic [VW:0]             trial;
   logic                    trial_ge;
   logic [CNT_W+SW-1:0]     seg_last_wide;
   logic [CNT_W+SW-1:0]     seg_lo_wide;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign is_interior = (count_ff >= CNT_W'(2)) && (req_chan.value > first_ff)
                        && (req_chan.value < last_ff);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign num_calc = VW'(value_ff - e0_ff);
   assign den_calc = VW'(rd_data_ff - e0_ff);
   assign trial    = {rem_ff[VW-1:0], 1'b0};
   assign trial_ge = (trial >= {1'b0, den_ff});

   // low bits of count-2 and lo-1, zero-extended for narrow tables
   assign seg_last_wide = {{SW{1'b0}}, count_ff - CNT_W'(2)};
   assign seg_lo_wide   = {{SW{1'b0}}, CNT_W'(lo_ff) - CNT_W'(1)};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            if (accept) begin
               if (req_chan.command == isl_pkg::CMD_QUERY && is_interior) begin
                  state_in = isl_pkg::S_SEARCH;
               end else begin
                  state_in = isl_pkg::S_DONE;
               end
            end
         end
         isl_pkg::S_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? isl_pkg::S_CMP : isl_pkg::S_LOAD0;
         end
         isl_pkg::S_CMP:   state_in = isl_pkg::S_SEARCH;
         isl_pkg::S_LOAD0: state_in = isl_pkg::S_LOAD1;
         isl_pkg::S_LOAD1: state_in = isl_pkg::S_DIV;
         isl_pkg::S_DIV: begin
            if (step_ff == 4'(FB - 1)) state_in = isl_pkg::S_DONE;
         end
         isl_pkg::S_DONE: begin
            if (rsp_chan.ready) state_in = isl_pkg::S_IDLE;
         end
         default: state_in = isl_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in  = count_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      value_in  = value_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      e0_in     = e0_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      seg_in    = seg_ff;
      frac_in   = frac_ff;
      status_in = status_ff;
      rd_addr   = lo_ff;
      wr_en     = 1'b0;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            if (accept) begin
               value_in  = req_chan.value;
               seg_in    = '0;
               frac_in   = isl_pkg::FRAC_ZERO;
               status_in = isl_pkg::ST_OK;
               lo_in     = IDX_W'(1);
               hi_in     = IDX_W'(count_ff - CNT_W'(1));
               case (req_chan.command)
                  isl_pkg::CMD_CLEAR: count_in = '0;
                  isl_pkg::CMD_APPEND: begin
                     if (is_full) begin
                        status_in = isl_pkg::ST_FULL;
                     end else if (count_ff != '0 && req_chan.value <= last_ff) begin
                        status_in = isl_pkg::ST_ORDER;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        last_in  = req_chan.value;
                        if (count_ff == '0) first_in = req_chan.value;
                     end
                  end
                  isl_pkg::CMD_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = isl_pkg::ST_EMPTY;
                     end else if (count_ff != CNT_W'(1) && req_chan.value > first_ff
                                  && req_chan.value >= last_ff) begin
                        seg_in  = seg_last_wide[SW-1:0];
                        frac_in = isl_pkg::FRAC_ONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         isl_pkg::S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr = mid_calc;
               mid_in  = mid_calc;
            end else begin
               rd_addr = lo_ff - IDX_W'(1);
            end
         end
         isl_pkg::S_CMP: begin
            if (rd_data_ff >= value_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + IDX_W'(1);
            end
         end
         isl_pkg::S_LOAD0: begin
            e0_in   = rd_data_ff;
            rd_addr = lo_ff;
         end
         isl_pkg::S_LOAD1: begin
            // value lies in (E[lo-1], E[lo]], so num <= den and the top quotient bit
            // is set only when value hits the upper breakpoint
            den_in  = den_calc;
            step_in = '0;
            if (num_calc >= den_calc) begin
               rem_in  = {1'b0, num_calc - den_calc};
               frac_in = FW'(1);
            end else begin
               rem_in  = {1'b0, num_calc};
               frac_in = '0;
            end
         end
         isl_pkg::S_DIV: begin
            rem_in  = trial_ge ? (trial - {1'b0, den_ff}) : trial;
            frac_in = {frac_ff[FW-2:0], trial_ge};
            step_in = step_ff + 4'd1;
            seg_in  = seg_lo_wide[SW-1:0];
         end
         default: ;
      endcase
   end

   assign req_chan.ready         = (state_ff == isl_pkg::S_IDLE);
   assign rsp_chan.valid         = (state_ff == isl_pkg::S_DONE);
   assign rsp_chan.segment_index = seg_ff;
   assign rsp_chan.fraction      = frac_ff;
   assign rsp_chan.status        = status_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bp_mem[count_ff[IDX_W-1:0]] <= req_chan.value;
      end
      rd_data_ff <= bp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isl_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      e0_ff     <= e0_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      step_ff   <= step_in;
      seg_ff    <= seg_in;
      frac_ff   <= frac_in;
      status_ff <= status_in;
   end

endmodule
